// File: hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol-to-ASCII mapping of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int BYTE_W      = 8;
  localparam int CHAR_W      = 8;
  localparam int SYM_W       = 6;
  localparam int SLOTS       = 4;
  localparam int SLOT_IDX_W  = $clog2(SLOTS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

  // one output character before translation: a 6-bit symbol or padding
  typedef struct packed {
    logic             pad;
    logic [SYM_W-1:0] sym;
  } b64e_slot_t;

  // work produced by one input byte
  typedef struct packed {
    b64e_slot_t [SLOTS-1:0]  slots;
    logic [SLOT_IDX_W-1:0]   last_idx;
    logic                    eom;
  } b64e_entry_t;

  function automatic logic [CHAR_W-1:0] sym_to_ascii(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] v8;
    logic [CHAR_W-1:0] c;
    v8 = {{(CHAR_W-SYM_W){1'b0}}, v};
    if (v < 6'd26) begin
      c = 8'h41 + v8;
    end else if (v < 6'd52) begin
      c = 8'h61 + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/b64e_ifs.sv
// ----------------------------------------------------------------------------
// b64e channel interfaces
// Valid/ready channels for raw bytes in and encoded characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64e_in_if
  import b64e_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_message;

  modport source(output valid, output data_byte, output end_of_message, input ready);
  modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if
  import b64e_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              final_char;

  modport source(output valid, output ascii_char, output final_char, input ready);
  modport sink(input valid, input ascii_char, input final_char, output ready);
endinterface

`default_nettype wire

// File: hdl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Takes raw bytes, tracks the group phase and leftover bits, and turns each
// byte into a queue entry of one to four symbols.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  b64e_in_if.sink     bytes,
  input  wire logic   full,
  output logic        push,
  output b64e_entry_t entry
);

  logic [1:0] phase;
  logic [3:0] leftover;
  logic [1:0] phase_next;
  logic [3:0] leftover_next;

  logic [BYTE_W-1:0] b;
  logic              last;

  assign b    = bytes.data_byte;
  assign last = bytes.end_of_message;

  assign bytes.ready = !full;
  assign push        = bytes.valid && !full;

  always_comb begin
    entry         = '0;
    entry.eom     = last;
    phase_next    = phase;
    leftover_next = leftover;
    case (phase)
      2'd1: begin
        entry.slots[0].sym = {leftover[1:0], b[7:4]};
        if (last) begin
          entry.slots[1].sym = {b[3:0], 2'b00};
          entry.slots[2].pad = 1'b1;
          entry.last_idx     = 2'd2;
        end else begin
          entry.last_idx = 2'd0;
          leftover_next  = b[3:0];
          phase_next     = 2'd2;
        end
      end
      2'd2: begin
        entry.slots[0].sym = {leftover, b[7:6]};
        entry.slots[1].sym = b[5:0];
        entry.last_idx     = 2'd1;
        leftover_next      = 4'd0;
        phase_next         = 2'd0;
      end
      default: begin
        entry.slots[0].sym = b[7:2];
        if (last) begin
          entry.slots[1].sym = {b[1:0], 4'b0000};
          entry.slots[2].pad = 1'b1;
          entry.slots[3].pad = 1'b1;
          entry.last_idx     = 2'd3;
        end else begin
          entry.last_idx = 2'd0;
          leftover_next  = {2'b00, b[1:0]};
          phase_next     = 2'd1;
        end
      end
    endcase
    if (last) begin
      phase_next    = 2'd0;
      leftover_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short FIFO of symbol entries between the byte front end and the
// character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire b64e_entry_t  wr_entry,
  input  wire logic         pop,
  output b64e_entry_t       head,
  output logic              full,
  output logic              empty
);

  b64e_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head entry one slot per cycle unless stalled, maps symbols to
// ASCII and holds each character in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire b64e_entry_t  head,
  input  wire logic         empty,
  output logic              pop,
  b64e_out_if.source        chars
);

  logic [SLOT_IDX_W-1:0] idx;
  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_final;

  logic       load;
  logic       at_end;
  b64e_slot_t slot;

  assign slot   = head.slots[idx];
  assign at_end = (idx == head.last_idx);
  assign load   = !empty && (!out_valid || chars.ready);
  assign pop    = load && at_end;

  assign chars.valid      = out_valid;
  assign chars.ascii_char = out_char;
  assign chars.final_char = out_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // character payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= slot.pad ? PAD_CHAR : sym_to_ascii(slot.sym);
      out_final <= head.eom && at_end;
    end
  end

endmodule

`default_nettype wire

// File: hdl/base64_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_encoder_core
// Streaming base64 encoder with the standard alphabet and '=' padding.
// ----------------------------------------------------------------------------
// Raw bytes enter on the bytes channel, end_of_message marking the last byte
// of a message; encoded ASCII characters leave on the chars channel, one per
// cycle while it is ready, with final_char set on the last character of the
// message. The front end turns each byte into one to four symbols
// combinationally and queues them in a two-entry FIFO; the back end emits one
// character per cycle unless stalled, from a registered output. The output
// port sets the pace: a byte yields one character at group phases 0 and 1
// and two at phase 2, and a closing byte two to four. Bytes keep being taken
// while characters of earlier bytes wait, as long as the FIFO has room.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_core
  import b64e_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  b64e_in_if.sink    bytes,
  b64e_out_if.source chars
);

  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  b64e_entry_t wr_entry;
  b64e_entry_t head;

  b64e_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  b64e_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .chars (chars)
  );

endmodule

`default_nettype wire

// File: tb/sv/base64_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// base64_encoder_core_tb
// Self-checking bench for the streaming base64 encoder. A directed table of
// short messages is followed by random messages with random byte values.
// Random idle cycles appear on both channels. Every character that leaves
// is compared with the table's string or, for rows without one and random
// bytes, a bit-accurate encoder model kept in step with each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_core_tb;
  import b64e_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_BYTES = 86;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS = 40;

  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [CHAR_W-1:0] ascii;
    logic              fin;
  } enc_char_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              eom;
    string             chars;  // empty: taken from the encoder model
  } msg_row_t;

  localparam int DIR_ROWS = 24;

  msg_row_t msg_table [0:DIR_ROWS-1] = '{
    '{8'h00, 1'b1, "AA=="},
    '{8'hFF, 1'b1, "/w=="},
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b1, "/8="},
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b1, "//"},
    '{8'h00, 1'b0, "A"},
    '{8'h00, 1'b0, "A"},
    '{8'h00, 1'b1, "AA"},
    '{8'h4D, 1'b0, "T"},
    '{8'h61, 1'b0, "W"},
    '{8'h6E, 1'b1, "Fu"},
    '{8'h4D, 1'b0, "T"},
    '{8'h61, 1'b1, "WE="},
    '{8'h4D, 1'b1, "TQ=="},
    '{8'h00, 1'b0, ""},
    '{8'h01, 1'b0, ""},
    '{8'h02, 1'b0, ""},
    '{8'h03, 1'b0, ""},
    '{8'h04, 1'b0, ""},
    '{8'h05, 1'b0, ""},
    '{8'h06, 1'b0, ""},
    '{8'h07, 1'b1, ""}
  };

  logic clk;
  logic rst;

  b64e_in_if  bytes_if ();
  b64e_out_if chars_if ();

  base64_encoder_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .chars (chars_if)
  );

  // encoder model state
  logic [1:0] grp_phase;
  logic [3:0] carry_bits;

  enc_char_t pending_chars [$];
  int        err_count;
  bit        steady;  // no idle cycles on either side while set

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic int encode_byte(input logic [BYTE_W-1:0] b, input logic eom,
                                     output enc_char_t c [4]);
    int n;
    case (grp_phase)
      2'd1: begin
        c[0] = '{B64_ALPHABET[{carry_bits[1:0], b[7:4]}], 1'b0};
        if (eom) begin
          c[1] = '{B64_ALPHABET[{b[3:0], 2'b00}], 1'b0};
          c[2] = '{PAD_CHAR, 1'b1};
          n = 3;
        end else begin
          carry_bits = b[3:0];
          grp_phase = 2'd2;
          n = 1;
        end
      end
      2'd2: begin
        c[0] = '{B64_ALPHABET[{carry_bits, b[7:6]}], 1'b0};
        c[1] = '{B64_ALPHABET[b[5:0]], eom};
        carry_bits = 4'd0;
        grp_phase = 2'd0;
        n = 2;
      end
      default: begin
        c[0] = '{B64_ALPHABET[b[7:2]], 1'b0};
        if (eom) begin
          c[1] = '{B64_ALPHABET[{b[1:0], 4'b0000}], 1'b0};
          c[2] = '{PAD_CHAR, 1'b0};
          c[3] = '{PAD_CHAR, 1'b1};
          n = 4;
        end else begin
          carry_bits = {2'b00, b[1:0]};
          grp_phase = 2'd1;
          n = 1;
        end
      end
    endcase
    if (eom) begin
      grp_phase = 2'd0;
      carry_bits = 4'd0;
    end
    return n;
  endfunction

  // returns at the edge of the transfer with valid still high
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eom,
                           input string typed);
    int        gap;
    int        n;
    enc_char_t c [4];
    enc_char_t tc;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.data_byte <= b;
    bytes_if.end_of_message <= eom;
    do @(posedge clk); while (bytes_if.ready !== 1'b1);
    n = encode_byte(b, eom, c);
    if (typed.len() == 0) begin
      for (int i = 0; i < n; i++) pending_chars.insert(pending_chars.size(), c[i]);
    end else begin
      for (int i = 0; i < typed.len(); i++) begin
        tc.ascii = typed[i];
        tc.fin   = eom && (i == typed.len() - 1);
        pending_chars.insert(pending_chars.size(), tc);
      end
    end
  endtask

  initial begin : char_sink
    int        stall;
    enc_char_t want;
    chars_if.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        chars_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      chars_if.ready <= 1'b1;
      do @(posedge clk); while (chars_if.valid !== 1'b1);
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h final %0b",
                                  chars_if.ascii_char, chars_if.final_char));
      end else begin
        want = pending_chars.pop_front();
        if (chars_if.ascii_char !== want.ascii) begin
          report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                    chars_if.ascii_char, want.ascii));
        end
        if (chars_if.final_char !== want.fin) begin
          report_mismatch($sformatf("final_char %0b, expected %0b on 0x%02h",
                                    chars_if.final_char, want.fin, want.ascii));
        end
      end
    end
  end

  initial begin : byte_source
    int                sent;
    int                msg_len;
    int                pick;
    logic [BYTE_W-1:0] b;
    clk = 1'b0;
    rst = 1'b1;
    bytes_if.valid = 1'b0;
    bytes_if.data_byte = '0;
    bytes_if.end_of_message = 1'b0;
    grp_phase = 2'd0;
    carry_bits = 4'd0;
    err_count = 0;
    steady = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_byte(msg_table[r].data, msg_table[r].eom, msg_table[r].chars);
    end

    // whole messages, so every group phase gets reached and closed
    while (sent < RAND_BYTES) begin
      msg_len = $urandom_range(1, 9);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < msg_len; i++) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: begin
            b = 8'h00;
          end
          1: begin
            b = 8'hFF;
          end
          default: begin
            b = 8'($urandom_range(0, 255));
          end
        endcase
        send_byte(b, i == msg_len - 1, "");
        sent++;
      end
    end
    bytes_if.valid <= 1'b0;
    steady = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
